// File: rtl/core/hhpd_pkg.sv
package hhpd_pkg;

  // Default sizes
  localparam int MAX_NODES_DEF     = 64;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int STACK_DEPTH_DEF   = 32;

  // Payload widths
  localparam int SYMBOL_W = 8;
  localparam int STATUS_W = 2;

  // Characters of the header grammar and the body
  localparam logic [SYMBOL_W-1:0] CH_LPAREN = 8'h28;  // (
  localparam logic [SYMBOL_W-1:0] CH_RPAREN = 8'h29;  // )
  localparam logic [SYMBOL_W-1:0] CH_COMMA  = 8'h2C;  // ,
  localparam logic [SYMBOL_W-1:0] CH_ZERO   = 8'h30;  // 0
  localparam logic [SYMBOL_W-1:0] CH_ONE    = 8'h31;  // 1
  localparam logic [SYMBOL_W-1:0] CH_A      = 8'h61;  // a
  localparam logic [SYMBOL_W-1:0] CH_Z      = 8'h7A;  // z

  // Marker text that separates the header from the body
  localparam int               MARK_POS_W = 4;
  localparam logic [MARK_POS_W-1:0] MARK_LEN = 4'd9;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_LETTER = 2'd0,
    STATUS_SYNTAX = 2'd1,
    STATUS_MARKER = 2'd2
  } status_t;

  // Decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_MARKER = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  // Parse stage of an open tree node
  typedef enum logic [1:0] {
    STG_LEFT  = 2'd0,
    STG_COMMA = 2'd1,
    STG_RIGHT = 2'd2,
    STG_CLOSE = 2'd3
  } stage_t;

  // Character of the marker text at a position
  function automatic logic [SYMBOL_W-1:0] marker_char(input logic [MARK_POS_W-1:0] pos);
    logic [SYMBOL_W-1:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h48;  // H
      4'd1:    ch = 8'h45;  // E
      4'd2:    ch = 8'h41;  // A
      4'd3:    ch = 8'h44;  // D
      4'd4:    ch = 8'h45;  // E
      4'd5:    ch = 8'h52;  // R
      4'd6:    ch = 8'h45;  // E
      4'd7:    ch = 8'h4E;  // N
      4'd8:    ch = 8'h44;  // D
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/core/hhpd_if.sv
interface hhpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [hhpd_pkg::SYMBOL_W-1:0] symbol;
  logic                          restart;

  modport source (output valid, output symbol, output restart, input ready);
  modport sink   (input valid, input symbol, input restart, output ready);
endinterface

interface hhpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [hhpd_pkg::SYMBOL_W-1:0] letter;
  logic [hhpd_pkg::STATUS_W-1:0] status;

  modport source (output valid, output letter, output status, input ready);
  modport sink   (input valid, input letter, input status, output ready);
endinterface

// File: rtl/core/hhpd_ram.sv
module hhpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/huffman_header_parse_and_decode.sv
// Huffman header parser and decoder.
// in_ch carries one character per transaction (symbol) and a restart flag.
// A transaction with restart set clears the tree and is parsed as the first
// header character. The header is a parenthesized tree such as (a,(b,c)),
// followed by the text HEADEREND; body characters '1' and '0' then walk to
// the left and right child, and each leaf reached is sent on out_ch with
// status 0, after which the walk restarts at the root. A syntax error
// (status 1) or marker mismatch (status 2) is sent once with letter 0, and
// the block stays silent until the next restart.
// An accepted character is decoded from the input register, and its
// result, if any, is held in the result register. Throughput is one
// character per cycle while out_ch is not stalled: the current tree node
// is held on the registered read port of the node RAM and the entry below
// the top of the parse stack on the registered read port of the stack RAM,
// both addressed with next state so they are ready for the next character.
// Reset (rst_n low, synchronous) empties both pipeline stages and enters
// header parsing; no clearing pass is needed. When out_ch is stalled the
// result is held, one more character is taken into the input register and
// in_ch.ready then drops until the result is taken.
module huffman_header_parse_and_decode #(
  parameter int MAX_NODES     = hhpd_pkg::MAX_NODES_DEF,
  parameter int ALPHABET_SIZE = hhpd_pkg::ALPHABET_SIZE_DEF,
  parameter int STACK_DEPTH   = hhpd_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  hhpd_in_if.sink           in_ch,
  hhpd_out_if.source        out_ch
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SYW = hhpd_pkg::SYMBOL_W;
  localparam logic [SYW-1:0] LetterLast = SYW'(32'h61 + ALPHABET_SIZE - 1);

  // Open node on the parse stack, with its left child once attached
  typedef struct packed {
    logic [NW-1:0]    node;
    hhpd_pkg::stage_t stage;
    logic [NW-1:0]    lidx;
    logic [SYW-1:0]   llet;
  } stk_t;

  // Internal tree node: both children and their letters (0 = internal)
  typedef struct packed {
    logic [NW-1:0]  lidx;
    logic [SYW-1:0] llet;
    logic [NW-1:0]  ridx;
    logic [SYW-1:0] rlet;
  } node_t;

  // Input register
  logic           s1_vld_r;
  logic [SYW-1:0] s1_sym_r;
  logic           s1_rst_r;
  logic           advance;

  // Decoder state
  hhpd_pkg::phase_t             phase_r, phase_nxt;
  logic [SW:0]                  sp_r, sp_nxt;
  logic [NW:0]                  cnt_r, cnt_nxt;
  logic [hhpd_pkg::MARK_POS_W-1:0] mpos_r, mpos_nxt;
  logic [NW-1:0]                cur_r, cur_nxt;
  stk_t                         top_r, top_nxt;
  logic                         byp_r, byp_nxt;
  stk_t                         byp_data_r;

  // Result register
  logic                 out_vld_r;
  logic [SYW-1:0]       out_letter_r;
  hhpd_pkg::status_t    out_status_r;
  logic                 res_vld;
  logic [SYW-1:0]       res_letter;
  hhpd_pkg::status_t    res_status;

  // Memory ports
  logic          nwe;
  logic [NW-1:0] nwaddr;
  node_t         nwdata;
  node_t         nrdata;
  logic          swe;
  logic [SW-1:0] swaddr;
  stk_t          swdata;
  logic [SW-1:0] sraddr;
  stk_t          srdata;
  stk_t          second;

  // Take a character when the input register is free or moves on
  assign advance     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || advance;

  assign out_ch.valid  = out_vld_r;
  assign out_ch.letter = out_letter_r;
  assign out_ch.status = out_status_r;

  // Entry under the top of stack, with the word written last cycle
  assign second = byp_r ? byp_data_r : srdata;

  // Decode one character
  always_comb begin
    hhpd_pkg::phase_t                e_phase;
    logic [SW:0]                     e_sp;
    logic [NW:0]                     e_cnt;
    logic [hhpd_pkg::MARK_POS_W-1:0] e_mpos;
    logic [NW-1:0]                   e_cur;
    logic                            at_start;
    logic                            want_child;
    logic                            is_lp;
    logic                            is_let;
    logic                            full;
    logic [NW-1:0]                   n;
    logic [SYW-1:0]                  child_let;
    stk_t                            top_att;
    logic [NW-1:0]                   nx;
    logic [SYW-1:0]                  nx_let;

    phase_nxt  = phase_r;
    sp_nxt     = sp_r;
    cnt_nxt    = cnt_r;
    mpos_nxt   = mpos_r;
    cur_nxt    = cur_r;
    top_nxt    = top_r;
    res_vld    = 1'b0;
    res_letter = '0;
    res_status = hhpd_pkg::STATUS_LETTER;
    nwe        = 1'b0;
    nwaddr     = top_r.node;
    nwdata     = '0;
    swe        = 1'b0;
    swaddr     = '0;
    swdata     = top_r;

    // Restart clears the state before this character is handled
    e_phase = s1_rst_r ? hhpd_pkg::PH_HEADER : phase_r;
    e_sp    = s1_rst_r ? '0 : sp_r;
    e_cnt   = s1_rst_r ? '0 : cnt_r;
    e_mpos  = s1_rst_r ? '0 : mpos_r;
    e_cur   = s1_rst_r ? '0 : cur_r;

    at_start   = (e_sp == '0);
    want_child = !at_start &&
                 (top_r.stage == hhpd_pkg::STG_LEFT || top_r.stage == hhpd_pkg::STG_RIGHT);
    is_lp      = (s1_sym_r == hhpd_pkg::CH_LPAREN);
    is_let     = (s1_sym_r >= hhpd_pkg::CH_A) && (s1_sym_r <= LetterLast) &&
                 (s1_sym_r <= hhpd_pkg::CH_Z);
    full       = (e_cnt >= (NW+1)'(MAX_NODES));
    n          = e_cnt[NW-1:0];
    child_let  = is_lp ? '0 : s1_sym_r;

    // Attach the new node as the child the top entry waits for
    top_att = top_r;
    if (top_r.stage == hhpd_pkg::STG_LEFT) begin
      top_att.lidx  = n;
      top_att.llet  = child_let;
      top_att.stage = hhpd_pkg::STG_COMMA;
    end else begin
      top_att.stage = hhpd_pkg::STG_CLOSE;
    end

    nx     = nrdata.ridx;
    nx_let = nrdata.rlet;
    if (s1_sym_r == hhpd_pkg::CH_ONE) begin
      nx     = nrdata.lidx;
      nx_let = nrdata.llet;
    end

    if (advance) begin
      phase_nxt = e_phase;
      sp_nxt    = e_sp;
      cnt_nxt   = e_cnt;
      mpos_nxt  = e_mpos;
      cur_nxt   = e_cur;

      unique case (e_phase)
        hhpd_pkg::PH_HEADER: begin
          priority if (is_lp) begin
            if (!(at_start || want_child) || full ||
                e_sp >= (SW+1)'(STACK_DEPTH)) begin
              res_vld    = 1'b1;
              res_status = hhpd_pkg::STATUS_SYNTAX;
              phase_nxt  = hhpd_pkg::PH_HALT;
            end else begin
              cnt_nxt = e_cnt + (NW+1)'(1);
              // Push: the updated parent moves into the stack RAM
              if (!at_start) begin
                swe    = 1'b1;
                swaddr = SW'(e_sp - (SW+1)'(1));
                swdata = top_att;
                if (top_r.stage != hhpd_pkg::STG_LEFT) begin
                  nwe    = 1'b1;
                  nwdata = '{lidx: top_r.lidx, llet: top_r.llet, ridx: n, rlet: '0};
                end
              end
              top_nxt = '{node: n, stage: hhpd_pkg::STG_LEFT, lidx: '0, llet: '0};
              sp_nxt  = e_sp + (SW+1)'(1);
            end
          end else if (is_let) begin
            if (!want_child || full) begin
              res_vld    = 1'b1;
              res_status = hhpd_pkg::STATUS_SYNTAX;
              phase_nxt  = hhpd_pkg::PH_HALT;
            end else begin
              cnt_nxt = e_cnt + (NW+1)'(1);
              top_nxt = top_att;
              if (top_r.stage != hhpd_pkg::STG_LEFT) begin
                nwe    = 1'b1;
                nwdata = '{lidx: top_r.lidx, llet: top_r.llet, ridx: n, rlet: s1_sym_r};
              end
            end
          end else if (s1_sym_r == hhpd_pkg::CH_COMMA) begin
            if (at_start || top_r.stage != hhpd_pkg::STG_COMMA) begin
              res_vld    = 1'b1;
              res_status = hhpd_pkg::STATUS_SYNTAX;
              phase_nxt  = hhpd_pkg::PH_HALT;
            end else begin
              top_nxt.stage = hhpd_pkg::STG_RIGHT;
            end
          end else if (s1_sym_r == hhpd_pkg::CH_RPAREN) begin
            if (at_start || top_r.stage != hhpd_pkg::STG_CLOSE) begin
              res_vld    = 1'b1;
              res_status = hhpd_pkg::STATUS_SYNTAX;
              phase_nxt  = hhpd_pkg::PH_HALT;
            end else begin
              // Pop: the entry below becomes the top
              sp_nxt  = e_sp - (SW+1)'(1);
              top_nxt = second;
              if (e_sp == (SW+1)'(1)) begin
                phase_nxt = hhpd_pkg::PH_MARKER;
                mpos_nxt  = '0;
              end
            end
          end else begin
            res_vld    = 1'b1;
            res_status = hhpd_pkg::STATUS_SYNTAX;
            phase_nxt  = hhpd_pkg::PH_HALT;
          end
        end

        hhpd_pkg::PH_MARKER: begin
          if (e_mpos >= hhpd_pkg::MARK_LEN ||
              s1_sym_r != hhpd_pkg::marker_char(e_mpos)) begin
            res_vld    = 1'b1;
            res_status = hhpd_pkg::STATUS_MARKER;
            phase_nxt  = hhpd_pkg::PH_HALT;
          end else begin
            mpos_nxt = e_mpos + hhpd_pkg::MARK_POS_W'(1);
            if (mpos_nxt == hhpd_pkg::MARK_LEN) begin
              phase_nxt = hhpd_pkg::PH_BODY;
              cur_nxt   = '0;
            end
          end
        end

        hhpd_pkg::PH_BODY: begin
          // Step to a child; a leaf emits its letter and returns to the root
          if (s1_sym_r == hhpd_pkg::CH_ONE || s1_sym_r == hhpd_pkg::CH_ZERO) begin
            if (nx_let != '0) begin
              res_vld    = 1'b1;
              res_letter = nx_let;
              cur_nxt    = '0;
            end else begin
              cur_nxt = nx;
            end
          end
        end

        hhpd_pkg::PH_HALT: begin
        end

        default: begin
        end
      endcase
    end

    // Keep the entry under the next top on the stack read port
    sraddr  = (sp_nxt >= (SW+1)'(2)) ? SW'(sp_nxt - (SW+1)'(2)) : '0;
    byp_nxt = swe && (swaddr == sraddr);
  end

  // Node table: written when a node's right child is attached
  hhpd_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (nwe),
    .waddr (nwaddr),
    .wdata (nwdata),
    .raddr (cur_nxt),
    .rdata (nrdata)
  );

  // Parse stack below the top entry
  hhpd_ram #(
    .WIDTH ($bits(stk_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (swe),
    .waddr (swaddr),
    .wdata (swdata),
    .raddr (sraddr),
    .rdata (srdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= hhpd_pkg::PH_HEADER;
      sp_r      <= '0;
      cnt_r     <= '0;
      mpos_r    <= '0;
      cur_r     <= '0;
      byp_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= res_vld;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      sp_r    <= sp_nxt;
      cnt_r   <= cnt_nxt;
      mpos_r  <= mpos_nxt;
      cur_r   <= cur_nxt;
      byp_r   <= byp_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_sym_r <= in_ch.symbol;
      s1_rst_r <= in_ch.restart;
    end
    if (advance) begin
      out_letter_r <= res_letter;
      out_status_r <= res_status;
    end
    top_r      <= top_nxt;
    byp_data_r <= swdata;
  end

  // Stack and node counts stay within their bounds
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= (SW+1)'(STACK_DEPTH))
    else $error("parse stack pointer beyond stack depth");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (NW+1)'(MAX_NODES))
    else $error("node count beyond node table size");

  // Halted decoder produces nothing without restart
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_r == hhpd_pkg::PH_HALT && !s1_rst_r) |=> !out_vld_r)
    else $error("result produced while halted");

  // Body decoding starts at the root
  a_body_root: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_r == hhpd_pkg::PH_MARKER && phase_nxt == hhpd_pkg::PH_BODY)
      |=> (cur_r == '0))
    else $error("body walk does not start at the root");

endmodule
